/* src/scale_reading_line_parser_assert.svh */
// assertion macros for the scale reading line parser checks
// both macros expect clock and reset to be visible where they are used
`ifndef SCALE_READING_LINE_PARSER_ASSERT_SVH
`define SCALE_READING_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define SLP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slp check failed");

// next-cycle implication
`define SLP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slp check failed");

`endif

/* src/slp_pkg.sv */
package slp_pkg;

   // default for the kept-character limit of the number search
   localparam int MAX_KEPT_DEFAULT = 63;
   // decimals in the scaled result
   localparam int FRAC_DIGITS = 3;
   // width of a fraction digit count
   localparam int FC_W = 3;

   // magnitude cap, one past the largest positive value
   localparam logic [31:0] MAG_CAP = 32'h8000_0000;

   // characters looked at in more than one place
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   // number scanner states
   localparam logic [2:0] SC_SEARCH = 3'd0;
   localparam logic [2:0] SC_PSIGN  = 3'd1;
   localparam logic [2:0] SC_PPOINT = 3'd2;
   localparam logic [2:0] SC_INT    = 3'd3;
   localparam logic [2:0] SC_FRAC   = 3'd4;
   localparam logic [2:0] SC_DONE   = 3'd5;

   // header modes
   localparam logic [1:0] HM_NONE  = 2'd0;
   localparam logic [1:0] HM_PLAIN = 2'd1;
   localparam logic [1:0] HM_US    = 2'd2;
   localparam logic [1:0] HM_OL    = 2'd3;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic              ok;
      logic              stable;
      logic signed [31:0] value_scaled;
      logic              saturated;
   } rsp_item_type;

   // what a scanner holds after the current character
   typedef struct packed {
      logic [2:0]      st;
      logic [31:0]     accum;
      logic [FC_W-1:0] fc;
      logic            neg;
      logic            sat;
   } scan_view_type;

   // header outcome after the current character
   typedef struct packed {
      logic [1:0] mode;
      logic       use_tail;
   } hdr_view_type;

   // everything the result stage needs for one line
   typedef struct packed {
      logic            ok;
      logic            stable;
      logic            neg;
      logic [31:0]     accum;
      logic [FC_W-1:0] fc;
      logic            sat;
   } line_summary_type;

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   // ten to the power n for the missing fraction digits
   function automatic logic [19:0] pow10(input logic [FC_W-1:0] n);
      case (n)
         3'd0: pow10 = 20'd1;
         3'd1: pow10 = 20'd10;
         3'd2: pow10 = 20'd100;
         3'd3: pow10 = 20'd1000;
         3'd4: pow10 = 20'd10000;
         3'd5: pow10 = 20'd100000;
         3'd6: pow10 = 20'd1000000;
         default: pow10 = 20'd1;
      endcase
   endfunction

endpackage

/* src/scale_reading_line_parser.sv */
// Weighing-scale line parser. One character of a text line is taken per item, and the block
// takes one item every clock cycle when the result side is not stalled. The single result of
// a line reaches the rsp side through registers: the item marked last is held in the input
// register while the per-character state update runs (header detection plus two number
// scanners, each a single add-and-compare per digit), then the line summary register holds
// the line while the scaling multiply feeds the result register. The summary register between
// the state update and the result stage lets the next line's characters flow in while a
// result waits.
// A NUL character ends the line early; characters after it are ignored until the last one.
module scale_reading_line_parser
   import slp_pkg::*;
#(
   parameter int MAX_KEPT = MAX_KEPT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;

   logic             sum_valid_ff, sum_valid_in;
   line_summary_type sum_ff, sum_in;
   logic             sum_take;

   logic          consume;
   logic          line_end;
   logic          feed;
   logic          tail_feed;
   hdr_view_type  hdr_view;
   scan_view_type whole_view;
   scan_view_type tail_view;
   scan_view_type pick;

   // a last item needs room in the summary register
   assign consume   = s1_valid_ff && (!s1_item_ff.last || !sum_valid_ff || sum_take);
   assign line_end  = consume && s1_item_ff.last;
   assign req_stall = s1_valid_ff && !consume;

   // input register
   assign s1_valid_in = (req_valid && !req_stall) || (s1_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_item_ff <= req_data;
      end
   end

   slp_header u_header (
      .clock     (clock),
      .reset     (reset),
      .step      (consume),
      .clear     (line_end),
      .ch        (s1_item_ff.ch),
      .feed      (feed),
      .tail_feed (tail_feed),
      .view      (hdr_view)
   );

   slp_scanner #(.MAX_KEPT(MAX_KEPT)) u_whole (
      .clock (clock),
      .reset (reset),
      .step  (feed),
      .clear (line_end),
      .ch    (s1_item_ff.ch),
      .view  (whole_view)
   );

   slp_scanner #(.MAX_KEPT(MAX_KEPT)) u_tail (
      .clock (clock),
      .reset (reset),
      .step  (tail_feed),
      .clear (line_end),
      .ch    (s1_item_ff.ch),
      .view  (tail_view)
   );

   // pick the scanner and judge the line
   assign pick = hdr_view.use_tail ? tail_view : whole_view;

   always_comb begin
      sum_in.ok     = (hdr_view.mode != HM_OL)
                      && (pick.st == SC_INT || pick.st == SC_FRAC || pick.st == SC_DONE);
      sum_in.stable = (hdr_view.mode != HM_US);
      sum_in.neg    = pick.neg;
      sum_in.accum  = pick.accum;
      sum_in.fc     = pick.fc;
      sum_in.sat    = pick.sat;
   end

   // line summary register
   assign sum_valid_in = line_end || (sum_valid_ff && !sum_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_end) begin
         sum_ff <= sum_in;
      end
   end

   slp_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid_ff),
      .sum       (sum_ff),
      .sum_take  (sum_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/slp_header.sv */
module slp_header
   import slp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         clear,
   input  logic [7:0]   ch,
   output logic         feed,
   output logic         tail_feed,
   output hdr_view_type view
);

   localparam logic [2:0] PH_BLANKS  = 3'd0;
   localparam logic [2:0] PH_FIRST   = 3'd1;
   localparam logic [2:0] PH_SECOND  = 3'd2;
   localparam logic [2:0] PH_DECIDED = 3'd3;
   localparam logic [2:0] PH_ENDED   = 3'd4;

   localparam logic [7:0] CH_O = 8'h4F;
   localparam logic [7:0] CH_L = 8'h4C;
   localparam logic [7:0] CH_U = 8'h55;
   localparam logic [7:0] CH_S = 8'h53;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] letters_ff, letters_in;
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  commas_ff, commas_in;

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
   endfunction

   // line phase, header letters and comma count
   always_comb begin
      phase_in   = phase_ff;
      letters_in = letters_ff;
      mode_in    = mode_ff;
      commas_in  = commas_ff;
      feed       = 1'b0;
      if (step && phase_ff != PH_ENDED) begin
         if (ch == CH_NUL) begin
            phase_in = PH_ENDED;
         end else if (!(phase_ff == PH_BLANKS && is_blank(ch))) begin
            feed = 1'b1;
            case (phase_ff)
               PH_BLANKS: begin
                  letters_in = {ch, 8'd0};
                  phase_in   = PH_FIRST;
               end
               PH_FIRST: begin
                  letters_in = {letters_ff[15:8], ch};
                  phase_in   = PH_SECOND;
               end
               PH_SECOND: begin
                  if (is_alpha(letters_ff[15:8]) && is_alpha(letters_ff[7:0])
                      && ch == CH_COMMA) begin
                     if (letters_ff[15:8] == CH_O && letters_ff[7:0] == CH_L) begin
                        mode_in = HM_OL;
                     end else if (letters_ff[15:8] == CH_U && letters_ff[7:0] == CH_S) begin
                        mode_in = HM_US;
                     end else begin
                        mode_in = HM_PLAIN;
                     end
                  end
                  phase_in = PH_DECIDED;
               end
               default: ;
            endcase
            if (ch == CH_COMMA && commas_ff != 2'd2) begin
               commas_in = commas_ff + 2'd1;
            end
         end
      end
   end

   // tail scanner only sees characters after the second comma
   assign tail_feed     = feed && (commas_ff == 2'd2);
   assign view.mode     = mode_in;
   assign view.use_tail = (mode_in != HM_NONE) && (commas_in == 2'd2);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff   <= PH_BLANKS;
         letters_ff <= '0;
         mode_ff    <= HM_NONE;
         commas_ff  <= 2'd0;
      end else begin
         phase_ff   <= phase_in;
         letters_ff <= letters_in;
         mode_ff    <= mode_in;
         commas_ff  <= commas_in;
      end
   end

endmodule

/* src/slp_scanner.sv */
module slp_scanner
   import slp_pkg::*;
#(
   parameter int MAX_KEPT = MAX_KEPT_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          clear,
   input  logic [7:0]    ch,
   output scan_view_type view
);

   localparam int KEPT_W = $clog2(MAX_KEPT + 1);

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;

   logic [2:0]        st_ff, st_in;
   logic [31:0]       accum_ff, accum_in;
   logic [FC_W-1:0]   fc_ff, fc_in;
   logic              neg_ff, neg_in;
   logic              sat_ff, sat_in;
   logic [KEPT_W-1:0] kept_ff, kept_in;

   logic        digit;
   logic [31:0] dval;
   logic [35:0] grown;
   logic        over;
   logic [31:0] stepped;

   // one decimal digit onto the accumulator, clamped at the cap
   assign digit   = ch inside {[8'h30:8'h39]};
   assign dval    = {28'd0, ch[3:0]};
   assign grown   = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1) + {32'd0, ch[3:0]};
   assign over    = grown > {4'd0, MAG_CAP};
   assign stepped = over ? MAG_CAP : grown[31:0];

   always_comb begin
      st_in    = st_ff;
      accum_in = accum_ff;
      fc_in    = fc_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      kept_in  = kept_ff;
      if (step && !is_blank(ch) && kept_ff < KEPT_W'(MAX_KEPT)) begin
         kept_in = kept_ff + KEPT_W'(1);
         case (st_ff)
            SC_INT: begin
               if (digit) begin
                  accum_in = stepped;
                  sat_in   = sat_ff | over;
               end else if (ch == CH_POINT) begin
                  st_in = SC_FRAC;
               end else begin
                  st_in = SC_DONE;
               end
            end
            SC_FRAC: begin
               if (digit) begin
                  if (fc_ff < FC_W'(FRAC_DIGITS)) begin
                     accum_in = stepped;
                     sat_in   = sat_ff | over;
                     fc_in    = fc_ff + FC_W'(1);
                  end
               end else begin
                  st_in = SC_DONE;
               end
            end
            SC_SEARCH, SC_PSIGN, SC_PPOINT: begin
               if (digit && st_ff == SC_PSIGN) begin
                  // sign followed by a digit
                  st_in    = SC_INT;
                  accum_in = dval;
               end else if (digit && st_ff == SC_PPOINT) begin
                  // point followed by a digit opens the fraction
                  st_in    = SC_FRAC;
                  accum_in = (FRAC_DIGITS > 0) ? dval : 32'd0;
                  fc_in    = (FRAC_DIGITS > 0) ? FC_W'(1) : FC_W'(0);
               end else if (digit) begin
                  st_in    = SC_INT;
                  neg_in   = 1'b0;
                  accum_in = dval;
               end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                  st_in  = SC_PSIGN;
                  neg_in = (ch == CH_MINUS);
               end else if (ch == CH_POINT) begin
                  st_in  = SC_PPOINT;
                  neg_in = 1'b0;
               end else begin
                  st_in = SC_SEARCH;
               end
            end
            default: ;
         endcase
      end
   end

   assign view.st    = st_in;
   assign view.accum = accum_in;
   assign view.fc    = fc_in;
   assign view.neg   = neg_in;
   assign view.sat   = sat_in;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         st_ff    <= SC_SEARCH;
         accum_ff <= '0;
         fc_ff    <= '0;
         neg_ff   <= 1'b0;
         sat_ff   <= 1'b0;
         kept_ff  <= '0;
      end else begin
         st_ff    <= st_in;
         accum_ff <= accum_in;
         fc_ff    <= fc_in;
         neg_ff   <= neg_in;
         sat_ff   <= sat_in;
         kept_ff  <= kept_in;
      end
   end

endmodule

/* src/slp_finish.sv */
module slp_finish
   import slp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             sum_valid,
   input  line_summary_type sum,
   output logic             sum_take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_item_type     rsp_data
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   logic [19:0] scale;
   logic [51:0] mag;
   logic        too_big;

   // scale up for missing fraction digits
   assign scale = pow10(FC_W'(FRAC_DIGITS) - sum.fc);
   assign mag   = {20'd0, sum.accum} * {32'd0, scale};

   always_comb begin
      rsp_data_in.ok           = sum.ok;
      rsp_data_in.stable       = sum.stable;
      rsp_data_in.value_scaled = 32'sd0;
      rsp_data_in.saturated    = 1'b0;
      if (sum.neg) begin
         too_big = sum.sat || (mag > {20'd0, MAG_CAP});
      end else begin
         too_big = sum.sat || (mag > {20'd0, MAG_CAP - 32'd1});
      end
      if (sum.ok) begin
         rsp_data_in.saturated = too_big;
         if (too_big) begin
            rsp_data_in.value_scaled = sum.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else if (sum.neg) begin
            rsp_data_in.value_scaled = 32'sd0 - $signed(mag[31:0]);
         end else begin
            rsp_data_in.value_scaled = $signed(mag[31:0]);
         end
      end
   end

   // result register
   assign sum_take     = sum_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = sum_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/slp_checker.sv */
`include "scale_reading_line_parser_assert.svh"

module slp_checker
   import slp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   // a line without a valid reading carries a clean zero
   `SLP_ASSERT_NOW(a_no_number_zero, rsp_valid && !rsp_data.ok, rsp_data.value_scaled == 32'sd0 && !rsp_data.saturated)

   // a clamped value sits at one of the two limits
   `SLP_ASSERT_NOW(a_clamp_at_limit, rsp_valid && rsp_data.saturated, rsp_data.ok && (rsp_data.value_scaled == 32'sh7FFF_FFFF || rsp_data.value_scaled == 32'sh8000_0000))

   // a waiting result item holds
   `SLP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a stalled input item holds
   `SLP_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_data))

endmodule

bind scale_reading_line_parser slp_checker u_checker (.*);

/* dv/reading_line_checker.sv */
// watches both channels of the scale reading line parser, predicts each
// line's reading and compares it with what the block returns
module reading_line_checker
   import slp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_data,
   output int           error_count,
   output int           readings_pending
);

   localparam int          KEPT_LIMIT = MAX_KEPT_DEFAULT;
   localparam logic [63:0] CAP_WIDE   = {32'd0, MAG_CAP};
   localparam logic [63:0] OVER_CAP   = {32'd0, MAG_CAP} + 64'd1;

   typedef enum logic [2:0] {
      LP_BLANKS, LP_FIRST, LP_SECOND, LP_DECIDED, LP_ENDED
   } line_phase_t;

   typedef struct packed {
      logic [2:0] st;
      logic [31:0] accum;
      logic [2:0] frac_cnt;
      logic       neg;
      logic [7:0] kept;
   } number_scan_t;

   // predicted line state
   line_phase_t  line_phase;
   logic [15:0]  header_letters;
   logic [1:0]   header_mode;
   logic [1:0]   comma_count;
   number_scan_t whole_scan;
   number_scan_t tail_scan;
   logic         whole_sat;
   logic         tail_sat;

   rsp_item_type expected_readings[$];
   rsp_item_type want;
   int           errors = 0;

   function automatic logic is_digit_char(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_space_or_tab(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   // accumulate one decimal digit, clamping at the magnitude cap
   function automatic void push_digit(inout number_scan_t s, input logic [7:0] c,
                                      inout logic sat);
      logic [63:0] nxt;
      nxt = {32'd0, s.accum} * 64'd10 + {56'd0, c - 8'h30};
      if (nxt > CAP_WIDE) begin
         sat = 1'b1;
         nxt = CAP_WIDE;
      end
      s.accum = nxt[31:0];
   endfunction

   function automatic void start_number(inout number_scan_t s, input logic [7:0] c,
                                        inout logic sat);
      if (is_digit_char(c)) begin
         s.st = SC_INT;
         s.neg = 1'b0;
         s.accum = '0;
         push_digit(s, c, sat);
      end else if ((c == "+") || (c == "-")) begin
         s.st = SC_PSIGN;
         s.neg = (c == "-");
      end else if (c == ".") begin
         s.st = SC_PPOINT;
         s.neg = 1'b0;
      end else begin
         s.st = SC_SEARCH;
      end
   endfunction

   // fraction digits past the kept decimals are dropped
   function automatic void push_frac(inout number_scan_t s, input logic [7:0] c,
                                     inout logic sat);
      if (s.frac_cnt < FRAC_DIGITS) begin
         push_digit(s, c, sat);
         s.frac_cnt = s.frac_cnt + 3'd1;
      end
   endfunction

   // one non-blank character through a number scanner
   function automatic void scan_char(inout number_scan_t s, input logic [7:0] c,
                                     inout logic sat);
      if (is_space_or_tab(c) || (s.kept >= KEPT_LIMIT))
         return;
      s.kept = s.kept + 8'd1;
      case (s.st)
         SC_SEARCH: start_number(s, c, sat);
         SC_PSIGN: begin
            if (is_digit_char(c)) begin
               s.st = SC_INT;
               s.accum = '0;
               push_digit(s, c, sat);
            end else begin
               start_number(s, c, sat);
            end
         end
         SC_PPOINT: begin
            if (is_digit_char(c)) begin
               s.st = SC_FRAC;
               s.accum = '0;
               s.frac_cnt = '0;
               push_frac(s, c, sat);
            end else begin
               start_number(s, c, sat);
            end
         end
         SC_INT: begin
            if (is_digit_char(c))
               push_digit(s, c, sat);
            else if (c == ".")
               s.st = SC_FRAC;
            else
               s.st = SC_DONE;
         end
         SC_FRAC: begin
            if (is_digit_char(c))
               push_frac(s, c, sat);
            else
               s.st = SC_DONE;
         end
         default: ;
      endcase
   endfunction

   function automatic void clear_line();
      line_phase = LP_BLANKS;
      header_letters = '0;
      header_mode = HM_NONE;
      comma_count = '0;
      whole_scan = '0;
      tail_scan = '0;
      whole_sat = 1'b0;
      tail_sat = 1'b0;
   endfunction

   // scaled reading of the finished line
   function automatic rsp_item_type line_result();
      number_scan_t s;
      logic         s_sat;
      logic [63:0]  mag;
      rsp_item_type r;
      r = '0;
      r.stable = 1'b1;
      if ((header_mode != HM_NONE) && (comma_count >= 2'd2)) begin
         s = tail_scan;
         s_sat = tail_sat;
      end else begin
         s = whole_scan;
         s_sat = whole_sat;
      end
      if (header_mode == HM_US)
         r.stable = 1'b0;
      if ((header_mode != HM_OL) &&
          ((s.st == SC_INT) || (s.st == SC_FRAC) || (s.st == SC_DONE))) begin
         r.ok = 1'b1;
         mag = {32'd0, s.accum};
         for (int i = s.frac_cnt; i < FRAC_DIGITS; i++) begin
            mag = mag * 64'd10;
            if (mag > CAP_WIDE)
               mag = OVER_CAP;
         end
         if (s_sat)
            mag = OVER_CAP;
         if (s.neg) begin
            if (mag > CAP_WIDE) begin
               r.saturated = 1'b1;
               r.value_scaled = 32'h8000_0000;
            end else begin
               r.value_scaled = 32'd0 - mag[31:0];
            end
         end else begin
            if (mag > 64'h7FFF_FFFF) begin
               r.saturated = 1'b1;
               r.value_scaled = 32'h7FFF_FFFF;
            end else begin
               r.value_scaled = mag[31:0];
            end
         end
      end
      return r;
   endfunction

   // advance the predicted line by one accepted character
   function automatic void take_char(input req_item_type item);
      logic [7:0] c;
      c = item.ch;
      if (line_phase != LP_ENDED) begin
         if (c == CH_NUL) begin
            line_phase = LP_ENDED;
         end else if (!((line_phase == LP_BLANKS) && is_space_or_tab(c))) begin
            case (line_phase)
               LP_BLANKS: begin
                  header_letters = {c, 8'h00};
                  line_phase = LP_FIRST;
               end
               LP_FIRST: begin
                  header_letters[7:0] = c;
                  line_phase = LP_SECOND;
               end
               LP_SECOND: begin
                  if (is_letter(header_letters[15:8]) && is_letter(header_letters[7:0]) &&
                      (c == CH_COMMA)) begin
                     if ((header_letters[15:8] == "O") && (header_letters[7:0] == "L"))
                        header_mode = HM_OL;
                     else if ((header_letters[15:8] == "U") && (header_letters[7:0] == "S"))
                        header_mode = HM_US;
                     else
                        header_mode = HM_PLAIN;
                  end
                  line_phase = LP_DECIDED;
               end
               default: ;
            endcase
            scan_char(whole_scan, c, whole_sat);
            if (comma_count >= 2'd2)
               scan_char(tail_scan, c, tail_sat);
            if ((c == CH_COMMA) && (comma_count < 2'd2))
               comma_count = comma_count + 2'd1;
         end
      end
      if (item.last) begin
         expected_readings.push_back(line_result());
         clear_line();
      end
   endfunction

   function automatic void check_field(input string field, input logic [31:0] exp_val,
                                       input logic [31:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s expected %0h got %0h", $time, field, exp_val, got_val);
         errors++;
      end
   endfunction

   // compare returned readings, then fold in the accepted character
   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         expected_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: reading expected none got ok=%0b stable=%0b value=%0h sat=%0b",
                        $time, rsp_data.ok, rsp_data.stable, rsp_data.value_scaled,
                        rsp_data.saturated);
               errors++;
            end else begin
               want = expected_readings.pop_front();
               check_field("ok", 32'(want.ok), 32'(rsp_data.ok));
               check_field("stable", 32'(want.stable), 32'(rsp_data.stable));
               check_field("value_scaled", want.value_scaled, rsp_data.value_scaled);
               check_field("saturated", 32'(want.saturated), 32'(rsp_data.saturated));
            end
         end
         if (req_valid && !req_stall)
            take_char(req_data);
      end
      error_count <= errors;
      readings_pending <= expected_readings.size();
   end

endmodule

/* dv/tb_top.sv */
module tb_top;
   import slp_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   int error_count;
   int readings_pending;
   int req_gap_pct = 0;
   int rsp_gap_pct = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int random_base;

   logic [7:0] line_chars[$];

   scale_reading_line_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   reading_line_checker i_reading_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .error_count      (error_count),
      .readings_pending (readings_pending)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_gap_pct);
   end

   // one character, held until the block takes it
   task automatic send_char(input logic [7:0] c, input logic lst);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{ch: c, last: lst};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic lst);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], lst && (i == s.len() - 1));
   endtask

   task automatic send_line();
      if (line_chars.size() == 0)
         send_char(CH_NUL, 1'b1);
      for (int i = 0; i < line_chars.size(); i++)
         send_char(line_chars[i], i == line_chars.size() - 1);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_chars.push_back(s[i]);
   endtask

   task automatic push_letter();
      line_chars.push_back(($urandom_range(1) ? "A" : "a") + 8'($urandom_range(25)));
   endtask

   task automatic push_digits(input int n);
      repeat (n) line_chars.push_back("0" + 8'($urandom_range(9)));
   endtask

   // drop the sender and let every outstanding reading come back
   task automatic drain_readings();
      req_valid <= 1'b0;
      do @(posedge clock); while (readings_pending != 0);
   endtask

   // mostly well-formed scale lines with random content, some noise
   task automatic make_reading_line();
      int kind;
      int hdr;
      int n;
      line_chars.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
         n = $urandom_range(1, 12);
         repeat (n) line_chars.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(2))
            line_chars.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
         hdr = $urandom_range(5);
         case (hdr)
            1: push_text("OL,");
            2: push_text("US,");
            3: push_text("ST,");
            4: begin
               push_letter();
               push_letter();
               line_chars.push_back(CH_COMMA);
            end
            5: begin
               push_letter();
               push_digits(1);
               line_chars.push_back(CH_COMMA);
            end
            default: ;
         endcase
         if ((hdr != 0) && ($urandom_range(9) < 7))
            push_text($urandom_range(1) ? "GS," : "NT,");
         // overlong line to hit the kept-character limit
         if ($urandom_range(19) == 0)
            repeat ($urandom_range(55, 64)) line_chars.push_back("#");
         case ($urandom_range(3))
            0: line_chars.push_back("-");
            1: line_chars.push_back("+");
            default: ;
         endcase
         n = ($urandom_range(7) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
         push_digits(n);
         if ($urandom_range(15) == 0)
            line_chars.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
         if ((n == 0) || ($urandom_range(9) < 7)) begin
            line_chars.push_back(".");
            push_digits($urandom_range(0, 6));
         end
         case ($urandom_range(5))
            0: push_text(" kg");
            1: push_text("g");
            2: begin
               line_chars.push_back($urandom_range(1) ? "e" : "x");
               push_digits(1);
            end
            3: push_text(",12");
            default: ;
         endcase
         // early terminator with junk behind it
         if ($urandom_range(9) == 0) begin
            line_chars.insert($urandom_range(line_chars.size()), CH_NUL);
            line_chars.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      send_char(CH_NUL, 1'b1);
      send_text(" \t ", 1'b1);
      send_text("OL,+0012.5kg", 1'b1);
      send_text("US,GS,-12.345kg", 1'b1);
      send_text("ST,NT,+0001.234 kg", 1'b1);
      send_text("ST,5", 1'b1);
      send_text("ab", 1'b1);
      send_text("-.5", 1'b1);
      send_text("12.34567", 1'b1);
      send_text("99999999999", 1'b1);
      send_text("-99999999999", 1'b1);
      send_text("-2147483.648", 1'b1);
      send_text("2147483.648", 1'b1);
      send_text("-0", 1'b1);
      send_text("1e5", 1'b1);
      send_text("0x1F", 1'b1);
      send_text(" 1 2\t3", 1'b1);
      send_text("12", 1'b0);
      send_char(CH_NUL, 1'b0);
      send_text("xx9", 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(8'h80, 1'b0);
      send_text("7", 1'b1);
      repeat (62) send_char("#", 1'b0);
      send_text("45", 1'b1);
      drain_readings();

      // random lines under three idling patterns
      random_base = items_sent;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_gap_pct = 7;
               rsp_gap_pct = 59;
            end
            1: begin
               req_gap_pct = 59;
               rsp_gap_pct = 7;
            end
            default: begin
               req_gap_pct = 0;
               rsp_gap_pct = 0;
            end
         endcase
         while (items_sent < random_base + RANDOM_ITEMS * (phase + 1) / 3) begin
            make_reading_line();
            send_line();
         end
         drain_readings();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
